FILE: rtl/ptr_pkg.sv
// Shared types and codes for the ping tracker ring.
// No dependencies; ptr_engine and ping_tracker_ring refer to it by scoped names.
package ptr_pkg;

  localparam logic KIND_ADD   = 1'b0;
  localparam logic KIND_CHECK = 1'b1;

  typedef enum logic [2:0] {
    ST_OK        = 3'd0,
    ST_ZERO_ID   = 3'd1,
    ST_MISMATCH  = 3'd2,
    ST_TIMED_OUT = 3'd3,
    ST_TOO_LONG  = 3'd4,
    ST_EMPTY     = 3'd5
  } status_t;

  typedef enum logic [2:0] {
    S_CLEAR,
    S_IDLE,
    S_SW_RD,
    S_SW_EV,
    S_ADD_RD,
    S_ADD_EV,
    S_CK_RD,
    S_CK_EV
  } eng_state_t;

  typedef struct packed {
    logic        kind;
    logic [31:0] now;
    logic [63:0] random_value;
    logic [63:0] payload_in;
    logic [3:0]  length;
    logic [63:0] ping_id_in;
  } req_item_t;

  typedef struct packed {
    status_t     status;
    logic [63:0] ping_id_out;
    logic [63:0] payload_out;
    logic [3:0]  length_out;
  } res_item_t;

  typedef struct packed {
    logic        occupied;
    logic [63:0] id;
    logic [31:0] stamp;
    logic [3:0]  length;
    logic [63:0] payload;
  } slot_t;

  // Expired when stamp + timeout <= now, formed 33 bits wide.
  function automatic logic expired(logic [31:0] stamp, logic [31:0] timeout,
                                   logic [31:0] now);
    logic [32:0] limit;
    limit = {1'b0, stamp} + {1'b0, timeout};
    return limit <= {1'b0, now};
  endfunction

endpackage

FILE: rtl/ptr_fifo.sv
// Small register queue used on both sides of the tracker engine.
// Depends on nothing; the payload is a flat vector of W bits.
module ptr_fifo #(
  parameter int W     = 8,
  parameter int DEPTH = 2
) (
  input  logic         clk,
  input  logic         rst,
  input  logic         wr,
  input  logic [W-1:0] wdata,
  output logic         full,
  input  logic         rd,
  output logic [W-1:0] rdata,
  output logic         empty
);
  localparam int PW = (DEPTH > 1) ? $clog2(DEPTH) : 1;

  logic [W-1:0]        store [DEPTH];
  logic [PW-1:0]       wp, rp;
  logic [$clog2(DEPTH+1)-1:0] count;

  logic do_wr, do_rd;
  assign do_wr = wr && !full;
  assign do_rd = rd && !empty;
  assign full  = count == ($clog2(DEPTH+1))'(DEPTH);
  assign empty = count == '0;
  assign rdata = store[rp];

  always_ff @(posedge clk) begin
    if (do_wr) begin
      store[wp] <= wdata;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      wp    <= '0;
      rp    <= '0;
      count <= '0;
    end else begin
      if (do_wr) begin
        wp <= (wp == PW'(DEPTH-1)) ? '0 : wp + 1'b1;
      end
      if (do_rd) begin
        rp <= (rp == PW'(DEPTH-1)) ? '0 : rp + 1'b1;
      end
      if (do_wr && !do_rd) begin
        count <= count + 1'b1;
      end else if (do_rd && !do_wr) begin
        count <= count - 1'b1;
      end
    end
  end
endmodule

FILE: rtl/ptr_engine.sv
// Back end of the ping tracker: slot memory, ring counters and the sequencer
// that sweeps, adds and checks. Depends on ptr_pkg.
module ptr_engine #(
  parameter int ENTRIES = 512
) (
  input  logic               clk,
  input  logic               rst,
  input  logic               cfg_wr_en,
  input  logic [31:0]        cfg_wr_data,
  input  logic               req_valid,
  input  ptr_pkg::req_item_t req,
  output logic               req_pop,
  input  logic               res_full,
  output logic               res_push,
  output ptr_pkg::res_item_t res,
  output logic               clearing
);
  localparam int IDXW = $clog2(ENTRIES);
  localparam int CNTW = IDXW + 1;

  ptr_pkg::slot_t     mem [ENTRIES];
  ptr_pkg::slot_t     rdata, wdata;
  logic [IDXW-1:0]    raddr, waddr, clear_idx;
  logic               we;

  ptr_pkg::eng_state_t state, state_next;
  ptr_pkg::req_item_t  cur;
  logic [CNTW-1:0]     oldest, oldest_next, newest, newest_next;
  logic [31:0]         timeout;

  logic [63:0]         new_id, masked_payload;
  logic [3:0]          sat_len;
  ptr_pkg::status_t    ck_status;
  logic                sw_expired;

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata <= mem[raddr];
  end

  assign sw_expired = ptr_pkg::expired(rdata.stamp, timeout, cur.now);
  assign sat_len    = (cur.length > 4'd8) ? 4'd8 : cur.length;

  always_comb begin
    for (int b = 0; b < 8; b++) begin
      masked_payload[8*b +: 8] = (4'(b) < sat_len) ? cur.payload_in[8*b +: 8] : 8'h00;
    end
  end

  always_comb begin
    new_id = {cur.random_value[63:IDXW], newest[IDXW-1:0]};
    if (new_id == 64'd0) begin
      new_id = 64'(ENTRIES);
    end
  end

  always_comb begin
    priority if (cur.ping_id_in == 64'd0) begin
      ck_status = ptr_pkg::ST_ZERO_ID;
    end else if (rdata.id != cur.ping_id_in) begin
      ck_status = ptr_pkg::ST_MISMATCH;
    end else if (ptr_pkg::expired(rdata.stamp, timeout, cur.now)) begin
      ck_status = ptr_pkg::ST_TIMED_OUT;
    end else if (rdata.length > cur.length) begin
      ck_status = ptr_pkg::ST_TOO_LONG;
    end else if (!rdata.occupied) begin
      ck_status = ptr_pkg::ST_EMPTY;
    end else begin
      ck_status = ptr_pkg::ST_OK;
    end
  end

  // Next state and counters.
  always_comb begin
    state_next  = state;
    oldest_next = oldest;
    newest_next = newest;
    unique case (state)
      ptr_pkg::S_CLEAR: begin
        if (clear_idx == IDXW'(ENTRIES-1)) state_next = ptr_pkg::S_IDLE;
      end
      ptr_pkg::S_IDLE: begin
        if (req_valid && !res_full) begin
          if (req.kind == ptr_pkg::KIND_CHECK) begin
            state_next = ptr_pkg::S_CK_RD;
          end else if (oldest != newest) begin
            state_next = ptr_pkg::S_SW_RD;
          end else begin
            state_next = ptr_pkg::S_ADD_RD;
          end
        end
      end
      ptr_pkg::S_SW_RD:  state_next = ptr_pkg::S_SW_EV;
      ptr_pkg::S_SW_EV: begin
        if (sw_expired) begin
          oldest_next = oldest + 1'b1;
          state_next  = (oldest_next == newest) ? ptr_pkg::S_ADD_RD : ptr_pkg::S_SW_RD;
        end else begin
          state_next = ptr_pkg::S_ADD_RD;
        end
      end
      ptr_pkg::S_ADD_RD: state_next = ptr_pkg::S_ADD_EV;
      ptr_pkg::S_ADD_EV: begin
        if (rdata.occupied) oldest_next = {~newest[IDXW], newest[IDXW-1:0]};
        newest_next = newest + 1'b1;
        state_next  = ptr_pkg::S_IDLE;
      end
      ptr_pkg::S_CK_RD:  state_next = ptr_pkg::S_CK_EV;
      ptr_pkg::S_CK_EV:  state_next = ptr_pkg::S_IDLE;
      default:           state_next = ptr_pkg::S_IDLE;
    endcase
  end

  // Outputs: memory port, queue handshakes and the result.
  always_comb begin
    raddr    = '0;
    we       = 1'b0;
    waddr    = '0;
    wdata    = '0;
    req_pop  = 1'b0;
    res_push = 1'b0;
    res      = '0;
    clearing = 1'b0;
    unique case (state)
      ptr_pkg::S_CLEAR: begin
        clearing = 1'b1;
        we       = 1'b1;
        waddr    = clear_idx;
      end
      ptr_pkg::S_IDLE:   req_pop = req_valid && !res_full;
      ptr_pkg::S_SW_RD:  raddr = oldest[IDXW-1:0];
      ptr_pkg::S_SW_EV: begin
        if (sw_expired) begin
          we    = 1'b1;
          waddr = oldest[IDXW-1:0];
        end
      end
      ptr_pkg::S_ADD_RD: raddr = newest[IDXW-1:0];
      ptr_pkg::S_ADD_EV: begin
        we            = 1'b1;
        waddr         = newest[IDXW-1:0];
        wdata.occupied = 1'b1;
        wdata.id      = new_id;
        wdata.stamp   = cur.now;
        wdata.length  = sat_len;
        wdata.payload = masked_payload;
        res_push      = 1'b1;
        res.status    = ptr_pkg::ST_OK;
        res.ping_id_out = new_id;
      end
      ptr_pkg::S_CK_RD:  raddr = cur.ping_id_in[IDXW-1:0];
      ptr_pkg::S_CK_EV: begin
        res_push   = 1'b1;
        res.status = ck_status;
        if (ck_status == ptr_pkg::ST_OK) begin
          we              = 1'b1;
          waddr           = cur.ping_id_in[IDXW-1:0];
          res.payload_out = rdata.payload;
          res.length_out  = rdata.length;
        end
      end
      default: ;
    endcase
  end

  always_ff @(posedge clk) begin
    if (req_pop) begin
      cur <= req;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state     <= ptr_pkg::S_CLEAR;
      clear_idx <= '0;
      oldest    <= '0;
      newest    <= '0;
      timeout   <= 32'd5;
    end else begin
      state  <= state_next;
      oldest <= oldest_next;
      newest <= newest_next;
      if (state == ptr_pkg::S_CLEAR) clear_idx <= clear_idx + 1'b1;
      if (cfg_wr_en) timeout <= cfg_wr_data;
    end
  end
endmodule

FILE: rtl/ping_tracker_ring.sv
// Top level of the ping tracker ring: request queue, engine, result queue.
// Depends on ptr_pkg, ptr_fifo and ptr_engine.
//
// Usage. Requests enter through a queue interface: a request is taken at a
// rising edge with push high and full low. Kind add stores a payload and
// returns a fresh id; kind check validates an id and returns its payload.
// Results leave through a queue: while empty is low the oldest result sits
// on the result port and is taken at an edge with pop high. The user writes
// the timeout register with cfg_wr_en/cfg_wr_data while idle; the block does
// not enforce this. Sequencing. The engine handles one request at a time
// and uses the single read port of the slot memory once per step: a read
// state, then an evaluate state. A check is one such step; an add first
// sweeps from the oldest entry, one step for each timed-out entry it retires
// and for the live entry it stops at, and then one step on its own slot.
// Reset. After rst the engine clears the slot memory, one slot a cycle, over
// all ENTRIES slots (512 by default); full stays high during that pass.
// Stalls. When the receiver stops popping, the result queue fills and the
// engine holds; the request queue still takes up to two further requests.
// ENTRIES must be a power of two.
module ping_tracker_ring #(
  parameter int ENTRIES = 512
) (
  input  logic               clk,
  input  logic               rst,
  input  logic               push,
  output logic               full,
  input  ptr_pkg::req_item_t request,
  output logic               empty,
  input  logic               pop,
  output ptr_pkg::res_item_t result,
  input  logic               cfg_wr_en,
  input  logic [31:0]        cfg_wr_data
);
  localparam int REQW = $bits(ptr_pkg::req_item_t);
  localparam int RESW = $bits(ptr_pkg::res_item_t);

  logic               rq_full, rq_empty, rq_pop, clearing;
  logic               rs_full, rs_push;
  logic [REQW-1:0]    rq_data;
  logic [RESW-1:0]    rs_data;
  ptr_pkg::res_item_t eng_res;

  // No requests are taken while the memory clearing pass runs.
  assign full = rq_full || clearing;

  ptr_fifo #(.W(REQW), .DEPTH(2)) u_req_q (
    .clk   (clk),
    .rst   (rst),
    .wr    (push && !clearing),
    .wdata (REQW'(request)),
    .full  (rq_full),
    .rd    (rq_pop),
    .rdata (rq_data),
    .empty (rq_empty)
  );

  ptr_engine #(.ENTRIES(ENTRIES)) u_engine (
    .clk         (clk),
    .rst         (rst),
    .cfg_wr_en   (cfg_wr_en),
    .cfg_wr_data (cfg_wr_data),
    .req_valid   (!rq_empty),
    .req         (ptr_pkg::req_item_t'(rq_data)),
    .req_pop     (rq_pop),
    .res_full    (rs_full),
    .res_push    (rs_push),
    .res         (eng_res),
    .clearing    (clearing)
  );

  ptr_fifo #(.W(RESW), .DEPTH(2)) u_res_q (
    .clk   (clk),
    .rst   (rst),
    .wr    (rs_push),
    .wdata (RESW'(eng_res)),
    .full  (rs_full),
    .rd    (pop),
    .rdata (rs_data),
    .empty (empty)
  );

  assign result = ptr_pkg::res_item_t'(rs_data);
endmodule
